@@ sv/tks_pkg.sv @@
// Package with the constants and shared types of the top-K sorted insert block.
package tks_pkg;

	// Number of entries the table holds.
	localparam int CAPACITY = 20;
	// Bits of an entry index, and of a count that can reach CAPACITY.
	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);

	localparam int SCORE_W = 32;
	localparam int TAG_W   = 64;
	localparam int RANK_W  = 5;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic insert;   // take the input word into the table, restart the read index
		logic advance;  // step the read index to the next rank
	} tks_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic last;     // the read index sits on the final stored entry
	} tks_status_t;

	// Controller states, one-hot.
	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EMIT = 2'b10
	} tks_state_t;

endpackage

@@ sv/tks_ifs.sv @@
// Valid/ready channel interfaces for the input word and the result word.
interface tks_item_if;
	logic                valid;
	logic                ready;
	logic signed [31:0]  score;
	logic        [63:0]  player_tag;

	modport source (output valid, output score, output player_tag, input ready);
	modport sink   (input valid, input score, input player_tag, output ready);
endinterface

interface tks_result_if;
	logic                valid;
	logic                ready;
	logic        [4:0]   rank;
	logic signed [31:0]  entry_score;
	logic        [63:0]  entry_tag;
	logic        [4:0]   placed_at;
	logic                last;

	modport source (output valid, output rank, output entry_score, output entry_tag,
		output placed_at, output last, input ready);
	modport sink   (input valid, input rank, input entry_score, input entry_tag,
		input placed_at, input last, output ready);
endinterface

@@ sv/tks_ctrl.sv @@
// Controller state machine: accepts a word, then walks the table out word by word.
module tks_ctrl
	import tks_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	output logic        out_valid,
	input  logic        out_ready,
	input  tks_status_t status,
	output tks_cmd_t    cmd
);

	tks_state_t state_q;
	tks_state_t state_d;

	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		out_valid   = 1'b0;
		cmd         = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.insert = 1'b1;
					state_d    = ST_EMIT;
				end
			end
			ST_EMIT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (status.last) begin
						state_d = ST_IDLE;
					end else begin
						cmd.advance = 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ sv/tks_dp.sv @@
// Datapath: the sorted score and tag table, the insert network and the read-out port.
module tks_dp
	import tks_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  tks_cmd_t                   cmd,
	output tks_status_t                status,
	input  logic signed [SCORE_W-1:0]  new_score,
	input  logic        [TAG_W-1:0]    new_tag,
	output logic        [RANK_W-1:0]   rank,
	output logic signed [SCORE_W-1:0]  entry_score,
	output logic        [TAG_W-1:0]    entry_tag,
	output logic        [RANK_W-1:0]   placed_at
);

	logic signed [SCORE_W-1:0] score_q [CAPACITY];
	logic        [TAG_W-1:0]   tag_q   [CAPACITY];
	logic        [CNT_W-1:0]   count_q;
	logic        [IDX_W-1:0]   idx_q;
	logic        [CNT_W-1:0]   placed_q;

	logic [CAPACITY-1:0] ge;
	logic [CNT_W-1:0]    pos;
	logic                dropped;

	// Stored entries at or above the new score form a prefix of the table,
	// so the insert position is the length of that prefix.
	always_comb begin
		pos = '0;
		for (int j = 0; j < CAPACITY; j++) begin
			ge[j] = (CNT_W'(j) < count_q) && (score_q[j] >= new_score);
			if (ge[j]) begin
				pos = CNT_W'(j + 1);
			end
		end
		dropped = (pos == CNT_W'(CAPACITY));
	end

	// Each slot keeps its entry, takes the new one, or takes its upper neighbor.
	always_ff @(posedge clk) begin
		if (cmd.insert && !dropped) begin
			if (!ge[0]) begin
				score_q[0] <= new_score;
				tag_q[0]   <= new_tag;
			end
			for (int j = 1; j < CAPACITY; j++) begin
				if (!ge[j]) begin
					if (ge[j-1]) begin
						score_q[j] <= new_score;
						tag_q[j]   <= new_tag;
					end else begin
						score_q[j] <= score_q[j-1];
						tag_q[j]   <= tag_q[j-1];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q   <= '0;
		end else begin
			if (cmd.insert) begin
				idx_q <= '0;
				if (count_q != CNT_W'(CAPACITY)) begin
					count_q <= count_q + CNT_W'(1);
				end
			end else if (cmd.advance) begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.insert) begin
			placed_q <= pos;
		end
	end

	assign status.last = (CNT_W'(idx_q) == count_q - CNT_W'(1));
	assign rank        = RANK_W'(idx_q);
	assign entry_score = score_q[idx_q];
	assign entry_tag   = tag_q[idx_q];
	assign placed_at   = RANK_W'(placed_q);

endmodule

@@ sv/top_k_sorted_insert_top.sv @@
// Top level of the top-K sorted insert block: controller, datapath and assertions.
//
// The block keeps a table of up to 20 (score, tag) entries sorted by score, highest
// first; entries with equal scores stay in arrival order. An input word is accepted
// only while the block is idle, and it is placed into the table in the same clock
// edge that accepts it, by comparing its score against every stored entry at once.
// The whole table is then sent out in rank order, one result word per cycle while the
// output is ready, with last set on the final entry and placed_at giving the rank the
// new entry took, or 20 when a full table did not take it. No new input word is accepted
// until the whole table has been sent; the single result port delivers one entry a
// cycle while the output is ready. The table starts empty after reset and needs no
// clearing pass.
module top_k_sorted_insert_top
	import tks_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	tks_item_if.sink     item,
	tks_result_if.source result
);

	tks_cmd_t    cmd;
	tks_status_t status;

	tks_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.status    (status),
		.cmd       (cmd)
	);

	tks_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.new_score   (item.score),
		.new_tag     (item.player_tag),
		.rank        (result.rank),
		.entry_score (result.entry_score),
		.entry_tag   (result.entry_tag),
		.placed_at   (result.placed_at)
	);

	assign result.last = status.last;

	// An accepted word is always followed by its table in the next cycle.
	a_accept_then_emit: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready |=> result.valid)
		else $error("no result after an accepted word");

	// Input and output never run at the same time.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(item.ready && result.valid))
		else $error("input ready while emitting");

	// After the final word the block returns to accepting input.
	a_last_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.ready && result.last |=> item.ready)
		else $error("block not idle after the final word");

	// Ranks step by one within an emitted table, and placed_at holds.
	a_rank_steps: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.ready && !result.last |=>
			result.valid && (result.rank == $past(result.rank) + 5'd1)
			&& $stable(result.placed_at))
		else $error("rank sequence broken");

endmodule
